### rtl/bpe_pkg.sv
`default_nettype none

package bpe_pkg;

    // field and register widths
    localparam int SAMPLE_BITS    = 24;
    localparam int GRID_BITS      = 9;
    localparam int GAIN_BITS      = 32;
    localparam int LEVEL_BITS     = 48;
    localparam int PIXEL_BITS     = 48;
    localparam int INDEX_BITS     = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 48;

    localparam int MAX_GRID_WIDTH_DEFAULT = 256;
    localparam int MIN_GRID_WIDTH         = 4;
    // first grid column or row at which a full stencil is present
    localparam int STENCIL_LEAD           = 3;
    localparam int QUEUE_DEPTH            = 4;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD  = 2'd2;

    localparam logic [GRID_BITS-1:0]         GRID_WIDTH_RESET = 9'd4;
    localparam logic [GAIN_BITS-1:0]         GAIN_RESET       = 32'd65536;
    localparam logic signed [LEVEL_BITS-1:0] THRESHOLD_RESET  = '0;

    // stencil weights
    localparam int CENTRE_WEIGHT   = 169;
    localparam int EDGE_WEIGHT     = 13;
    localparam int BILINEAR_WEIGHT = 144;

    // arithmetic widths
    localparam int CENTRE_BITS = SAMPLE_BITS + 2;
    localparam int EDGE_BITS   = SAMPLE_BITS + 3;
    localparam int CORNER_BITS = SAMPLE_BITS + 2;
    localparam int WEIGHT_BITS = SAMPLE_BITS + 10;
    localparam int FRAC_BITS   = 16;
    localparam int PART_BITS   = WEIGHT_BITS + FRAC_BITS + 1;
    localparam int FULL_BITS   = WEIGHT_BITS + GAIN_BITS + 1;
    localparam int SCALED_BITS = FULL_BITS - FRAC_BITS;
    localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

    localparam logic signed [PIXEL_BITS-1:0] PIXEL_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic signed [PIXEL_BITS-1:0] PIXEL_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          frame_start;
    } in_t;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] pixel_value;
        logic [INDEX_BITS-1:0]        pixel_column;
        logic [INDEX_BITS-1:0]        pixel_row;
        logic                         used_cubic;
        logic                         last_pixel;
    } out_t;

    // position tag that travels with each pixel
    typedef struct packed {
        logic                  last_pixel;
        logic [INDEX_BITS-1:0] pixel_row;
        logic [INDEX_BITS-1:0] pixel_column;
    } tag_t;

    // one line store row: the three previous grid rows at one column
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] line2;
        logic signed [SAMPLE_BITS-1:0] line1;
        logic signed [SAMPLE_BITS-1:0] line0;
    } line_row_t;

    typedef struct packed {
        logic signed [CENTRE_BITS-1:0] centre;
        logic signed [EDGE_BITS-1:0]   edge_sum;
        logic signed [CORNER_BITS-1:0] corner;
    } stencil_t;

endpackage

`default_nettype wire

### rtl/bpe_front.sv
`default_nettype none

module bpe_front #(
    parameter int MAX_GRID_WIDTH = bpe_pkg::MAX_GRID_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [bpe_pkg::GRID_BITS-1:0]         grid_width,
    input  logic                                  grid_restart,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  bpe_pkg::in_t                          s_payload,
    input  logic                                  queue_room,
    output logic                                  push,
    output logic signed [bpe_pkg::SAMPLE_BITS-1:0] push_sample,
    output logic [$clog2(MAX_GRID_WIDTH)-1:0]     push_addr,
    output logic                                  push_emit,
    output bpe_pkg::tag_t                         push_tag
);

    localparam int ADDR_BITS = $clog2(MAX_GRID_WIDTH);
    localparam int EW_BITS   = $clog2(MAX_GRID_WIDTH + 1);

    logic [ADDR_BITS-1:0] col_reg, row_reg;
    logic [ADDR_BITS-1:0] col_next, row_next;
    logic [ADDR_BITS-1:0] cur_col, cur_row;
    logic [31:0]          gw_wide;
    logic [EW_BITS-1:0]   eff_width, last_idx;
    logic                 col_at_end, row_at_end;

    // out-of-range widths are clamped
    assign gw_wide = 32'(grid_width);

    always_comb begin
        if (gw_wide < 32'(bpe_pkg::MIN_GRID_WIDTH)) begin
            eff_width = EW_BITS'(bpe_pkg::MIN_GRID_WIDTH);
        end else if (gw_wide > 32'(MAX_GRID_WIDTH)) begin
            eff_width = EW_BITS'(MAX_GRID_WIDTH);
        end else begin
            eff_width = EW_BITS'(gw_wide);
        end
    end

    assign last_idx = eff_width - EW_BITS'(1);

    assign cur_col    = s_payload.frame_start ? '0 : col_reg;
    assign cur_row    = s_payload.frame_start ? '0 : row_reg;
    assign col_at_end = (EW_BITS'(cur_col) == last_idx);
    assign row_at_end = (EW_BITS'(cur_row) == last_idx);

    always_comb begin
        col_next = cur_col + ADDR_BITS'(1);
        row_next = cur_row;
        if (col_at_end) begin
            col_next = '0;
            row_next = row_at_end ? '0 : cur_row + ADDR_BITS'(1);
        end
    end

    assign s_ready     = queue_room;
    assign push        = s_valid && queue_room;
    assign push_sample = s_payload.sample;
    assign push_addr   = cur_col;
    assign push_emit   = (32'(cur_col) >= 32'(bpe_pkg::STENCIL_LEAD))
                      && (32'(cur_row) >= 32'(bpe_pkg::STENCIL_LEAD));

    assign push_tag.pixel_column =
        bpe_pkg::INDEX_BITS'(32'(cur_col) - 32'(bpe_pkg::STENCIL_LEAD));
    assign push_tag.pixel_row =
        bpe_pkg::INDEX_BITS'(32'(cur_row) - 32'(bpe_pkg::STENCIL_LEAD));
    assign push_tag.last_pixel = col_at_end && row_at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn || grid_restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (push) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

### rtl/bpe_queue.sv
`default_nettype none

module bpe_queue #(
    parameter int MAX_GRID_WIDTH = bpe_pkg::MAX_GRID_WIDTH_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   push,
    input  logic signed [bpe_pkg::SAMPLE_BITS-1:0] push_sample,
    input  logic [$clog2(MAX_GRID_WIDTH)-1:0]      push_addr,
    input  logic                                   push_emit,
    input  bpe_pkg::tag_t                          push_tag,
    output logic                                   queue_room,
    input  logic                                   pop,
    output logic                                   q_valid,
    output logic signed [bpe_pkg::SAMPLE_BITS-1:0] q_sample,
    output logic [$clog2(MAX_GRID_WIDTH)-1:0]      q_addr,
    output logic                                   q_emit,
    output bpe_pkg::tag_t                          q_tag
);

    localparam int ADDR_BITS = $clog2(MAX_GRID_WIDTH);
    localparam int DEPTH     = bpe_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    logic signed [bpe_pkg::SAMPLE_BITS-1:0] sample_mem [DEPTH];
    logic [ADDR_BITS-1:0]                   addr_mem   [DEPTH];
    logic                                   emit_mem   [DEPTH];
    bpe_pkg::tag_t                          tag_mem    [DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign queue_room = (count_reg != CNT_BITS'(DEPTH));
    assign q_valid    = (count_reg != '0);
    assign q_sample   = sample_mem[rd_ptr_reg];
    assign q_addr     = addr_mem[rd_ptr_reg];
    assign q_emit     = emit_mem[rd_ptr_reg];
    assign q_tag      = tag_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            sample_mem[wr_ptr_reg] <= push_sample;
            addr_mem[wr_ptr_reg]   <= push_addr;
            emit_mem[wr_ptr_reg]   <= push_emit;
            tag_mem[wr_ptr_reg]    <= push_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_BITS'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_BITS'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != CNT_BITS'(DEPTH)))
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

### rtl/bpe_window.sv
`default_nettype none

module bpe_window #(
    parameter int MAX_GRID_WIDTH = bpe_pkg::MAX_GRID_WIDTH_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   q_valid,
    input  logic signed [bpe_pkg::SAMPLE_BITS-1:0] q_sample,
    input  logic [$clog2(MAX_GRID_WIDTH)-1:0]      q_addr,
    input  logic                                   q_emit,
    input  bpe_pkg::tag_t                          q_tag,
    output logic                                   pop,
    output logic                                   st_valid,
    output bpe_pkg::stencil_t                      st_sums,
    output bpe_pkg::tag_t                          st_tag,
    input  logic                                   st_ready
);

    localparam int ADDR_BITS = $clog2(MAX_GRID_WIDTH);
    localparam int WIN_SIDE  = 4;
    localparam int WIN_SIZE  = WIN_SIDE * WIN_SIDE;
    localparam int CB        = bpe_pkg::CENTRE_BITS;
    localparam int EB        = bpe_pkg::EDGE_BITS;
    localparam int KB        = bpe_pkg::CORNER_BITS;

    bpe_pkg::line_row_t line_mem [MAX_GRID_WIDTH];

    // line store read stage
    logic                                   m_valid_reg;
    logic signed [bpe_pkg::SAMPLE_BITS-1:0] m_sample_reg;
    logic [ADDR_BITS-1:0]                   m_addr_reg;
    logic                                   m_emit_reg;
    bpe_pkg::tag_t                          m_tag_reg;
    bpe_pkg::line_row_t                     rd_row_reg;
    bpe_pkg::line_row_t                     fwd_row_reg;
    logic                                   fwd_hit_reg;
    bpe_pkg::line_row_t                     cur_row, new_row;

    // window stage
    logic signed [bpe_pkg::SAMPLE_BITS-1:0] win_reg [WIN_SIZE];
    logic                                   w_valid_reg;
    bpe_pkg::tag_t                          w_tag_reg;

    // sum stage
    logic              sum_valid_reg;
    bpe_pkg::stencil_t sum_reg;
    bpe_pkg::tag_t     sum_tag_reg;

    logic sum_free, w_free, w_adv, m_adv;

    assign sum_free = !sum_valid_reg || st_ready;
    assign w_adv    = w_valid_reg && sum_free;
    assign w_free   = !w_valid_reg || sum_free;
    assign m_adv    = m_valid_reg && w_free;
    assign pop      = q_valid && (!m_valid_reg || m_adv);

    // a write to the same column in the cycle of the read is taken from the bypass
    assign cur_row       = fwd_hit_reg ? fwd_row_reg : rd_row_reg;
    assign new_row.line2 = cur_row.line1;
    assign new_row.line1 = cur_row.line0;
    assign new_row.line0 = m_sample_reg;

    always_ff @(posedge aclk) begin
        if (m_adv) begin
            line_mem[m_addr_reg] <= new_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_row_reg <= line_mem[q_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                m_valid_reg  <= 1'b1;
                m_sample_reg <= q_sample;
                m_addr_reg   <= q_addr;
                m_emit_reg   <= q_emit;
                m_tag_reg    <= q_tag;
                fwd_hit_reg  <= m_adv && (m_addr_reg == q_addr);
                fwd_row_reg  <= new_row;
            end else if (m_adv) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // window shifts one column left, new column on the right
    always_ff @(posedge aclk) begin
        if (m_adv) begin
            for (int r = 0; r < WIN_SIDE; r++) begin
                for (int c = 0; c < WIN_SIDE - 1; c++) begin
                    win_reg[r * WIN_SIDE + c] <= win_reg[r * WIN_SIDE + c + 1];
                end
            end
            win_reg[3]  <= cur_row.line2;
            win_reg[7]  <= cur_row.line1;
            win_reg[11] <= cur_row.line0;
            win_reg[15] <= m_sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else if (m_adv) begin
            w_valid_reg <= m_emit_reg;
            w_tag_reg   <= m_tag_reg;
        end else if (w_adv) begin
            w_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_free) begin
            sum_valid_reg <= w_valid_reg;
            if (w_valid_reg) begin
                sum_tag_reg        <= w_tag_reg;
                sum_reg.centre     <= CB'(win_reg[5]) + CB'(win_reg[6])
                                    + CB'(win_reg[9]) + CB'(win_reg[10]);
                sum_reg.edge_sum   <= EB'(win_reg[4])  + EB'(win_reg[8])
                                    + EB'(win_reg[13]) + EB'(win_reg[14])
                                    + EB'(win_reg[11]) + EB'(win_reg[7])
                                    + EB'(win_reg[2])  + EB'(win_reg[1]);
                sum_reg.corner     <= KB'(win_reg[0]) + KB'(win_reg[12])
                                    + KB'(win_reg[15]) + KB'(win_reg[3]);
            end
        end
    end

    assign st_valid = sum_valid_reg;
    assign st_sums  = sum_reg;
    assign st_tag   = sum_tag_reg;

`ifndef SYNTHESIS
    a_window_fills_from_read_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(w_valid_reg) |-> $past(m_adv))
        else $error("stencil became valid without a column shift");
`endif

endmodule

`default_nettype wire

### rtl/bpe_arith.sv
`default_nettype none

module bpe_arith (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [bpe_pkg::GAIN_BITS-1:0]         gain,
    input  logic signed [bpe_pkg::LEVEL_BITS-1:0] threshold,
    input  logic                                  st_valid,
    input  bpe_pkg::stencil_t                     st_sums,
    input  bpe_pkg::tag_t                         st_tag,
    output logic                                  st_ready,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output bpe_pkg::out_t                         m_payload
);

    localparam int WB    = bpe_pkg::WEIGHT_BITS;
    localparam int PB    = bpe_pkg::PART_BITS;
    localparam int FB    = bpe_pkg::FULL_BITS;
    localparam int SB    = bpe_pkg::SCALED_BITS;
    localparam int FRAC  = bpe_pkg::FRAC_BITS;
    localparam int LANES = 3;
    localparam int LANE_LINEAR   = 0;
    localparam int LANE_CUBIC    = 1;
    localparam int LANE_BILINEAR = 2;

    function automatic logic signed [bpe_pkg::PIXEL_BITS-1:0] saturate(
        input logic signed [SB-1:0] v
    );
        logic signed [bpe_pkg::PIXEL_BITS-1:0] r;
        if (v > SB'(bpe_pkg::PIXEL_MAX)) begin
            r = bpe_pkg::PIXEL_MAX;
        end else if (v < SB'(bpe_pkg::PIXEL_MIN)) begin
            r = bpe_pkg::PIXEL_MIN;
        end else begin
            r = bpe_pkg::PIXEL_BITS'(v);
        end
        return r;
    endfunction

    logic signed [WB-1:0] centre_w, lin_w, cub_w, bil_w;
    logic signed [FRAC:0] gain_hi, gain_lo;
    logic signed [FB-1:0] full [LANES];
    logic                 cubic;

    // weight stage
    logic                 a_valid_reg;
    logic signed [WB-1:0] wt_reg [LANES];
    bpe_pkg::tag_t        a_tag_reg;
    // partial product stage
    logic                 b_valid_reg;
    logic signed [PB-1:0] p_hi_reg [LANES];
    logic signed [PB-1:0] p_lo_reg [LANES];
    bpe_pkg::tag_t        b_tag_reg;
    // rounded level stage
    logic                 c_valid_reg;
    logic signed [SB-1:0] lvl_reg [LANES];
    bpe_pkg::tag_t        c_tag_reg;
    // output register
    logic                 o_valid_reg;
    bpe_pkg::out_t        o_reg;

    logic o_free, c_free, b_free, a_free;

    assign o_free   = !o_valid_reg || m_ready;
    assign c_free   = !c_valid_reg || o_free;
    assign b_free   = !b_valid_reg || c_free;
    assign a_free   = !a_valid_reg || b_free;
    assign st_ready = a_free;

    assign centre_w = WB'(st_sums.centre);
    assign lin_w    = centre_w * WB'(bpe_pkg::CENTRE_WEIGHT);
    assign cub_w    = lin_w - WB'(st_sums.edge_sum) * WB'(bpe_pkg::EDGE_WEIGHT)
                    + WB'(st_sums.corner);
    assign bil_w    = centre_w * WB'(bpe_pkg::BILINEAR_WEIGHT);

    // gain split in two 16 bit halves to keep each multiplier narrow
    assign gain_hi = $signed({1'b0, gain[bpe_pkg::GAIN_BITS-1:FRAC]});
    assign gain_lo = $signed({1'b0, gain[FRAC-1:0]});

    // w*gain + half, floored by the arithmetic shift
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            full[i] = (FB'(p_hi_reg[i]) <<< FRAC) + FB'(p_lo_reg[i])
                    + FB'(bpe_pkg::ROUND_HALF);
        end
    end

    assign cubic = (lvl_reg[LANE_LINEAR] >= SB'(threshold));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (a_free) begin
                a_valid_reg <= st_valid;
                if (st_valid) begin
                    wt_reg[LANE_LINEAR]   <= lin_w;
                    wt_reg[LANE_CUBIC]    <= cub_w;
                    wt_reg[LANE_BILINEAR] <= bil_w;
                    a_tag_reg             <= st_tag;
                end
            end
            if (b_free) begin
                b_valid_reg <= a_valid_reg;
                if (a_valid_reg) begin
                    for (int i = 0; i < LANES; i++) begin
                        p_hi_reg[i] <= PB'(wt_reg[i]) * PB'(gain_hi);
                        p_lo_reg[i] <= PB'(wt_reg[i]) * PB'(gain_lo);
                    end
                    b_tag_reg <= a_tag_reg;
                end
            end
            if (c_free) begin
                c_valid_reg <= b_valid_reg;
                if (b_valid_reg) begin
                    for (int i = 0; i < LANES; i++) begin
                        lvl_reg[i] <= full[i][FB-1:FRAC];
                    end
                    c_tag_reg <= b_tag_reg;
                end
            end
            if (o_free) begin
                o_valid_reg <= c_valid_reg;
                if (c_valid_reg) begin
                    o_reg.pixel_value  <= cubic ? saturate(lvl_reg[LANE_CUBIC])
                                                : saturate(lvl_reg[LANE_BILINEAR]);
                    o_reg.pixel_column <= c_tag_reg.pixel_column;
                    o_reg.pixel_row    <= c_tag_reg.pixel_row;
                    o_reg.used_cubic   <= cubic;
                    o_reg.last_pixel   <= c_tag_reg.last_pixel;
                end
            end
        end
    end

    assign m_valid   = o_valid_reg;
    assign m_payload = o_reg;

endmodule

`default_nettype wire

### rtl/bicubic_pixel_estimator_unit.sv
// bicubic pixel estimator
//
// grid samples enter on the s_ channel (valid/ready) in raster order, one
// transaction per grid point; frame_start marks the first point of a grid.
// a pixel estimate leaves on the m_ channel (valid/ready) for every grid
// point at column and row three or above, i.e. once a full 4x4 stencil is
// held; earlier points produce no output transaction.
// registers grid_width, gain and threshold_level are written through the
// cfg_ port (cfg_wr_en, cfg_index, cfg_data); the user must write them only
// while the block is idle, which the block itself does not enforce; writing
// grid_width restarts the column and row count. throughput is one sample
// per cycle unless m_ready stalls; a sample passes the queue and then one
// register each for the line store read, window, sums, weights, gain
// products, rounding and output. a stall on m_ready backs up the pipeline
// stage by stage, then the four-entry queue behind the input; s_ready drops.
// reset (aresetn low, synchronous) empties the pipeline and queue, clears
// the counters and loads the register defaults; line store and window
// contents are rewritten before any output depends on them, so no clearing
// pass is run.

`default_nettype none

module bicubic_pixel_estimator_unit #(
    parameter int MAX_GRID_WIDTH = bpe_pkg::MAX_GRID_WIDTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [bpe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bpe_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  bpe_pkg::in_t                         s_payload,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output bpe_pkg::out_t                        m_payload
);

    localparam int ADDR_BITS = $clog2(MAX_GRID_WIDTH);

    // configuration registers
    logic [bpe_pkg::GRID_BITS-1:0]         grid_width_reg;
    logic [bpe_pkg::GAIN_BITS-1:0]         gain_reg;
    logic signed [bpe_pkg::LEVEL_BITS-1:0] threshold_reg;
    logic                                  grid_restart;

    // front to queue
    logic                                   push, queue_room, push_emit;
    logic signed [bpe_pkg::SAMPLE_BITS-1:0] push_sample;
    logic [ADDR_BITS-1:0]                   push_addr;
    bpe_pkg::tag_t                          push_tag;

    // queue to window
    logic                                   pop, q_valid, q_emit;
    logic signed [bpe_pkg::SAMPLE_BITS-1:0] q_sample;
    logic [ADDR_BITS-1:0]                   q_addr;
    bpe_pkg::tag_t                          q_tag;

    // window to arithmetic
    logic              st_valid, st_ready;
    bpe_pkg::stencil_t st_sums;
    bpe_pkg::tag_t     st_tag;

    // register writes; an index beyond the list is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg <= bpe_pkg::GRID_WIDTH_RESET;
            gain_reg       <= bpe_pkg::GAIN_RESET;
            threshold_reg  <= bpe_pkg::THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bpe_pkg::REG_GRID_WIDTH: begin
                    grid_width_reg <= cfg_data[bpe_pkg::GRID_BITS-1:0];
                end
                bpe_pkg::REG_GAIN: begin
                    gain_reg <= cfg_data[bpe_pkg::GAIN_BITS-1:0];
                end
                bpe_pkg::REG_THRESHOLD: begin
                    threshold_reg <= $signed(cfg_data[bpe_pkg::LEVEL_BITS-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // a new grid width restarts the raster position
    assign grid_restart = cfg_wr_en && (cfg_index == bpe_pkg::REG_GRID_WIDTH);

    // front: raster position, stencil-complete and last-pixel flags
    bpe_front #(
        .MAX_GRID_WIDTH (MAX_GRID_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .grid_width   (grid_width_reg),
        .grid_restart (grid_restart),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .queue_room   (queue_room),
        .push         (push),
        .push_sample  (push_sample),
        .push_addr    (push_addr),
        .push_emit    (push_emit),
        .push_tag     (push_tag)
    );

    // short queue decoupling the front from the filter pipeline
    bpe_queue #(
        .MAX_GRID_WIDTH (MAX_GRID_WIDTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_sample (push_sample),
        .push_addr   (push_addr),
        .push_emit   (push_emit),
        .push_tag    (push_tag),
        .queue_room  (queue_room),
        .pop         (pop),
        .q_valid     (q_valid),
        .q_sample    (q_sample),
        .q_addr      (q_addr),
        .q_emit      (q_emit),
        .q_tag       (q_tag)
    );

    // line stores, 4x4 window and stencil sums
    bpe_window #(
        .MAX_GRID_WIDTH (MAX_GRID_WIDTH)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_sample (q_sample),
        .q_addr   (q_addr),
        .q_emit   (q_emit),
        .q_tag    (q_tag),
        .pop      (pop),
        .st_valid (st_valid),
        .st_sums  (st_sums),
        .st_tag   (st_tag),
        .st_ready (st_ready)
    );

    // weighting, gain, threshold choice and saturation
    bpe_arith u_arith (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain      (gain_reg),
        .threshold (threshold_reg),
        .st_valid  (st_valid),
        .st_sums   (st_sums),
        .st_tag    (st_tag),
        .st_ready  (st_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

### test/bpe_pixel_checker.sv
`default_nettype none

module bpe_pixel_checker #(
    parameter int MAX_GRID_WIDTH = bpe_pkg::MAX_GRID_WIDTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bpe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bpe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  bpe_pkg::in_t                       s_payload,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  bpe_pkg::out_t                      m_payload,
    output int                                 fail_count,
    output int                                 pending
);

    // shadow copy of the block state
    logic signed [bpe_pkg::SAMPLE_BITS-1:0] line_mem [0:3*MAX_GRID_WIDTH-1];
    logic signed [bpe_pkg::SAMPLE_BITS-1:0] stencil_win [0:15];
    int unsigned                            col_cnt;
    int unsigned                            row_cnt;
    logic [bpe_pkg::GRID_BITS-1:0]          width_reg;
    logic [bpe_pkg::GAIN_BITS-1:0]          gain_reg;
    logic signed [bpe_pkg::LEVEL_BITS-1:0]  level_reg;

    bpe_pkg::out_t pending_pixels [$];
    int            bad_pixels = 0;

    // integer part exact, fractional part rounded half up to Q.16
    function automatic longint scale_by_gain(input longint w);
        longint hi;
        longint lo;
        hi = longint'(gain_reg[bpe_pkg::GAIN_BITS-1:bpe_pkg::FRAC_BITS]);
        lo = longint'(gain_reg[bpe_pkg::FRAC_BITS-1:0]);
        return w * hi + ((w * lo + bpe_pkg::ROUND_HALF) >>> bpe_pkg::FRAC_BITS);
    endfunction

    function automatic logic signed [bpe_pkg::PIXEL_BITS-1:0] clip_pixel(input longint v);
        longint top;
        top = (longint'(1) <<< (bpe_pkg::PIXEL_BITS - 1)) - 1;
        if (v > top) return bpe_pkg::PIXEL_MAX;
        if (v < -top - 1) return bpe_pkg::PIXEL_MIN;
        return v[bpe_pkg::PIXEL_BITS-1:0];
    endfunction

    function automatic longint px(input int r, input int c);
        return longint'(stencil_win[r*4 + c]);
    endfunction

    function automatic void estimate_pixel(input bpe_pkg::in_t item);
        int unsigned   side;
        int            r;
        longint        centre;
        longint        edges;
        longint        corners;
        longint        level;
        longint        v;
        logic          cubic;
        bpe_pkg::out_t pix;
        if (width_reg < bpe_pkg::MIN_GRID_WIDTH) side = bpe_pkg::MIN_GRID_WIDTH;
        else if (width_reg > MAX_GRID_WIDTH) side = MAX_GRID_WIDTH;
        else side = width_reg;

        if (item.frame_start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= side) col_cnt = 0;
        if (row_cnt >= side) row_cnt = 0;

        for (r = 0; r < 4; r++) begin
            stencil_win[r*4]     = stencil_win[r*4 + 1];
            stencil_win[r*4 + 1] = stencil_win[r*4 + 2];
            stencil_win[r*4 + 2] = stencil_win[r*4 + 3];
        end
        stencil_win[3]  = line_mem[2*MAX_GRID_WIDTH + col_cnt];
        stencil_win[7]  = line_mem[MAX_GRID_WIDTH + col_cnt];
        stencil_win[11] = line_mem[col_cnt];
        stencil_win[15] = item.sample;
        line_mem[2*MAX_GRID_WIDTH + col_cnt] = line_mem[MAX_GRID_WIDTH + col_cnt];
        line_mem[MAX_GRID_WIDTH + col_cnt]   = line_mem[col_cnt];
        line_mem[col_cnt]                    = item.sample;

        if (col_cnt >= bpe_pkg::STENCIL_LEAD && row_cnt >= bpe_pkg::STENCIL_LEAD) begin
            centre  = px(1, 1) + px(1, 2) + px(2, 1) + px(2, 2);
            edges   = px(1, 0) + px(2, 0) + px(3, 1) + px(3, 2)
                    + px(2, 3) + px(1, 3) + px(0, 2) + px(0, 1);
            corners = px(0, 0) + px(3, 0) + px(3, 3) + px(0, 3);
            level   = scale_by_gain(bpe_pkg::CENTRE_WEIGHT * centre);
            cubic   = level >= longint'(level_reg);
            if (cubic) begin
                v = scale_by_gain(bpe_pkg::CENTRE_WEIGHT * centre
                                  - bpe_pkg::EDGE_WEIGHT * edges + corners);
            end else begin
                v = scale_by_gain(bpe_pkg::BILINEAR_WEIGHT * centre);
            end
            pix.pixel_value  = clip_pixel(v);
            pix.pixel_column = bpe_pkg::INDEX_BITS'(col_cnt - bpe_pkg::STENCIL_LEAD);
            pix.pixel_row    = bpe_pkg::INDEX_BITS'(row_cnt - bpe_pkg::STENCIL_LEAD);
            pix.used_cubic   = cubic;
            pix.last_pixel   = (col_cnt == side - 1) && (row_cnt == side - 1);
            pending_pixels.push_back(pix);
        end

        col_cnt++;
        if (col_cnt >= side) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= side) row_cnt = 0;
        end
    endfunction

    function automatic void compare_pixel(input bpe_pkg::out_t got);
        bpe_pkg::out_t want;
        logic          ok;
        if (pending_pixels.size() == 0) begin
            $display("%0t: pixel with nothing expected, value %0d column %0d row %0d",
                     $time, got.pixel_value, got.pixel_column, got.pixel_row);
            bad_pixels++;
            return;
        end
        want = pending_pixels.pop_front();
        ok   = 1'b1;
        if (got.pixel_value !== want.pixel_value) begin
            $display("%0t: pixel_value expected %0d got %0d",
                     $time, want.pixel_value, got.pixel_value);
            ok = 1'b0;
        end
        if (got.pixel_column !== want.pixel_column) begin
            $display("%0t: pixel_column expected %0d got %0d",
                     $time, want.pixel_column, got.pixel_column);
            ok = 1'b0;
        end
        if (got.pixel_row !== want.pixel_row) begin
            $display("%0t: pixel_row expected %0d got %0d",
                     $time, want.pixel_row, got.pixel_row);
            ok = 1'b0;
        end
        if (got.used_cubic !== want.used_cubic) begin
            $display("%0t: used_cubic expected %0b got %0b",
                     $time, want.used_cubic, got.used_cubic);
            ok = 1'b0;
        end
        if (got.last_pixel !== want.last_pixel) begin
            $display("%0t: last_pixel expected %0b got %0b",
                     $time, want.last_pixel, got.last_pixel);
            ok = 1'b0;
        end
        if (!ok) bad_pixels++;
    endfunction

    always @(posedge aclk) begin
        int i;
        if (!aresetn) begin
            for (i = 0; i < 3*MAX_GRID_WIDTH; i++) line_mem[i] = '0;
            for (i = 0; i < 16; i++) stencil_win[i] = '0;
            col_cnt   = 0;
            row_cnt   = 0;
            width_reg = bpe_pkg::GRID_WIDTH_RESET;
            gain_reg  = bpe_pkg::GAIN_RESET;
            level_reg = bpe_pkg::THRESHOLD_RESET;
            pending_pixels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    bpe_pkg::REG_GRID_WIDTH: begin
                        width_reg = cfg_data[bpe_pkg::GRID_BITS-1:0];
                        col_cnt   = 0;
                        row_cnt   = 0;
                    end
                    bpe_pkg::REG_GAIN:      gain_reg  = cfg_data[bpe_pkg::GAIN_BITS-1:0];
                    bpe_pkg::REG_THRESHOLD: level_reg = cfg_data[bpe_pkg::LEVEL_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) estimate_pixel(s_payload);
            if (m_valid && m_ready) compare_pixel(m_payload);
        end
        pending    <= pending_pixels.size();
        fail_count <= bad_pixels;
    end

endmodule

`default_nettype wire

### test/tb_bicubic_pixel_estimator_unit.sv
`default_nettype none

module tb_bicubic_pixel_estimator_unit;

    // receiver hold-off long enough to back up the pipeline and input queue
    localparam int LONG_HOLD      = 300;
    // cycles with no transaction on any port before the run is abandoned
    localparam int WATCHDOG_LIMIT = 4000;
    // pipeline latency plus margin, for items that carry no pixel
    localparam int DRAIN_CYCLES   = 12;
    // index with no register behind it, writes must be ignored
    localparam logic [bpe_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    localparam logic signed [bpe_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
        {1'b0, {(bpe_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [bpe_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
        {1'b1, {(bpe_pkg::SAMPLE_BITS-1){1'b0}}};

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [bpe_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [bpe_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    bpe_pkg::in_t                       s_payload = '0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    bpe_pkg::out_t                      m_payload;

    int fail_count;
    int pending;
    int stall_cycles = 0;

    // calm switches off all random idling for the closing part of the run
    bit calm       = 1'b0;
    int hold_asks  = 0;
    int holds_done = 0;

    always #5 aclk = ~aclk;

    bicubic_pixel_estimator_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    bpe_pixel_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // watchdog: any transaction or register write restarts the count
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_bicubic_pixel_estimator_unit NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver: random ready bursts and stalls, plus the long hold on request
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_asks != holds_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // offer one grid point and hold it until the transaction completes,
    // then now and again leave a gap on the input side
    task automatic put_sample(input logic signed [bpe_pkg::SAMPLE_BITS-1:0] smp,
                              input logic fs);
        bpe_pkg::in_t pkt;
        pkt.sample      = smp;
        pkt.frame_start = fs;
        s_valid   <= 1'b1;
        s_payload <= pkt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // stop sending and wait for every pixel still owed, then let the
    // pipeline empty of points that carry no pixel
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write enable is left high; the caller lowers it after the last write
    task automatic set_register(input logic [bpe_pkg::CFG_INDEX_BITS-1:0] idx,
                                input logic [bpe_pkg::CFG_DATA_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    function automatic logic signed [bpe_pkg::SAMPLE_BITS-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: begin
                v = int'($urandom_range(0, 511)) - 256;
                return v[bpe_pkg::SAMPLE_BITS-1:0];
            end
            default: return bpe_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [bpe_pkg::GAIN_BITS-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return bpe_pkg::GAIN_RESET;
            3: return bpe_pkg::GAIN_BITS'($urandom_range(0, 32'h3FFFF));
            default: return bpe_pkg::GAIN_BITS'($urandom);
        endcase
    endfunction

    // levels near zero matter most, since that is where the choice flips
    function automatic logic signed [bpe_pkg::LEVEL_BITS-1:0] pick_level();
        longint t;
        case ($urandom_range(0, 5))
            0: return bpe_pkg::PIXEL_MIN;
            1: return bpe_pkg::PIXEL_MAX;
            2: return '0;
            3, 4: begin
                t = longint'($signed($urandom)) <<< $urandom_range(0, 15);
                return t[bpe_pkg::LEVEL_BITS-1:0];
            end
            default: return bpe_pkg::LEVEL_BITS'({$urandom, $urandom});
        endcase
    endfunction

    // one setting of the registers followed by a stream of grid points;
    // mostly well-formed grids, some with a missing frame start (wrap) and,
    // on small grids, the odd frame start in the middle of a grid
    task automatic run_grid_phase(input int unsigned width,
                                  input logic [bpe_pkg::GAIN_BITS-1:0] gain,
                                  input logic signed [bpe_pkg::LEVEL_BITS-1:0] level,
                                  input int n_items, input bit squeeze, input bit poke_spare);
        int unsigned side;
        int unsigned pos;
        logic        fs;
        int          k;
        settle();
        set_register(bpe_pkg::REG_GRID_WIDTH, bpe_pkg::CFG_DATA_BITS'(width));
        set_register(bpe_pkg::REG_GAIN, bpe_pkg::CFG_DATA_BITS'(gain));
        set_register(bpe_pkg::REG_THRESHOLD, level);
        if (poke_spare) begin
            set_register(REG_SPARE, bpe_pkg::CFG_DATA_BITS'({$urandom, $urandom}));
        end
        cfg_wr_en <= 1'b0;
        if (squeeze) hold_asks++;

        if (width < bpe_pkg::MIN_GRID_WIDTH) side = bpe_pkg::MIN_GRID_WIDTH;
        else if (width > bpe_pkg::MAX_GRID_WIDTH_DEFAULT) side = bpe_pkg::MAX_GRID_WIDTH_DEFAULT;
        else side = width;

        pos = 0;
        for (k = 0; k < n_items; k++) begin
            if (pos == 0) fs = ($urandom_range(0, 4) != 0);
            else fs = (side <= 32) && ($urandom_range(0, 99) == 0);
            if (fs) pos = 0;
            put_sample(pick_sample(), fs);
            pos = (pos + 1) % (side * side);
        end
    endtask

    initial begin
        int p;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: 4x4 grid, unity gain, zero level
        // full grid with centre at the positive limit and edges at the
        // negative limit, so the cubic path takes the widest sum
        put_sample(-24'sd1,     1'b1);
        put_sample(SAMPLE_MIN,  1'b0);
        put_sample(SAMPLE_MIN,  1'b0);
        put_sample('0,          1'b0);
        put_sample(SAMPLE_MIN,  1'b0);
        put_sample(SAMPLE_MAX,  1'b0);
        put_sample(SAMPLE_MAX,  1'b0);
        put_sample(SAMPLE_MIN,  1'b0);
        put_sample(SAMPLE_MIN,  1'b0);
        put_sample(SAMPLE_MAX,  1'b0);
        put_sample(SAMPLE_MAX,  1'b0);
        put_sample(SAMPLE_MIN,  1'b0);
        put_sample(24'sd1,      1'b0);
        put_sample(SAMPLE_MIN,  1'b0);
        put_sample(SAMPLE_MIN,  1'b0);
        put_sample(SAMPLE_MAX,  1'b0);
        // no frame start: counting wraps into the next grid
        put_sample(24'h555555,  1'b0);
        put_sample(24'hAAAAAA,  1'b0);
        put_sample(SAMPLE_MAX,  1'b0);
        put_sample(SAMPLE_MIN,  1'b0);
        // frame start in the middle of a grid restarts the count
        put_sample('0,          1'b1);
        put_sample(24'h0F0F0F,  1'b0);
        put_sample(24'hF0F0F0,  1'b0);
        put_sample(SAMPLE_MAX,  1'b0);
        put_sample(SAMPLE_MIN,  1'b0);

        // register extremes: zero gain, always cubic, the top threshold with
        // saturating gain, widths below the minimum and above the maximum
        run_grid_phase(4, '0, '0, 40, 1'b0, 1'b0);
        run_grid_phase(5, bpe_pkg::GAIN_RESET, bpe_pkg::PIXEL_MIN, 40, 1'b0, 1'b0);
        run_grid_phase(8, '1, bpe_pkg::PIXEL_MAX, 60, 1'b0, 1'b0);
        run_grid_phase(0, pick_gain(), pick_level(), 40, 1'b0, 1'b1);
        run_grid_phase(3, 32'd1, -48'sd1, 30, 1'b0, 1'b0);
        // widest grid: three full rows and the first pixels of the fourth
        run_grid_phase(511, pick_gain(), '0, 775, 1'b0, 1'b0);
        // long receiver hold while the sender keeps offering grid points
        run_grid_phase(16, 32'h0001_8000, pick_level(), 100, 1'b1, 1'b0);
        for (p = 0; p < 3; p++) begin
            run_grid_phase($urandom_range(4, 8), pick_gain(), pick_level(), 30, 1'b0, 1'b0);
        end

        // closing part with no idling on either side
        calm = 1'b1;
        run_grid_phase(6, pick_gain(), pick_level(), 60, 1'b0, 1'b0);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb_bicubic_pixel_estimator_unit OK");
        end else begin
            $display("tb_bicubic_pixel_estimator_unit NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
